### src/cbc_pkg.sv
// Shared constants, types and helpers for the color blob centroid block.
`timescale 1ns / 1ps
package cbc_pkg;

  localparam int CoordBits   = 12;
  localparam int MaxDim      = 1 << CoordBits;
  localparam int DimRegBits  = 13;
  localparam int ColorBits   = 24;
  localparam int SumBits     = 3 * CoordBits;
  localparam int CountBits   = 2 * CoordBits + 1;
  localparam int CenterBits  = CoordBits + 1;
  localparam int StepBits    = $clog2(CoordBits + 1);
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = (ColorBits > DimRegBits) ? ColorBits : DimRegBits;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  localparam logic [CfgIdxBits-1:0] CfgImageWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgImageHeight = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgTargetColor = CfgIdxBits'(2);

  localparam logic [DimRegBits-1:0] WidthReset  = DimRegBits'(640);
  localparam logic [DimRegBits-1:0] HeightReset = DimRegBits'(480);

  // Accumulated totals of one finished frame
  typedef struct packed {
    logic [SumBits-1:0]   sum_x;
    logic [SumBits-1:0]   sum_y;
    logic [CountBits-1:0] count;
    logic [CoordBits-1:0] rightmost;
  } frame_t;

  // Last valid coordinate for a dimension register: 0 counts as 1, oversize clamps
  function automatic logic [CoordBits-1:0] last_index(input logic [DimRegBits-1:0] dim);
    logic [CoordBits-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (int'(dim) > MaxDim) begin
      res = CoordBits'(MaxDim - 1);
    end else begin
      res = CoordBits'(int'(dim) - 1);
    end
    return res;
  endfunction

endpackage

### src/cbc_front.sv
// Pixel intake: raster counters, color match and per-frame accumulation.
`timescale 1ns / 1ps
module cbc_front import cbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   pixel_valid_i,
  output logic                   pixel_ready_o,
  input  logic [ColorBits-1:0]   pixel_color_i,
  output logic                   frame_valid_o,
  input  logic                   frame_ready_i,
  output frame_t                 frame_o
);

  logic [DimRegBits-1:0] width_q, height_q;
  logic [ColorBits-1:0]  target_q;
  logic [CoordBits-1:0]  col_q, col_d, row_q, row_d;
  logic [SumBits-1:0]    sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CountBits-1:0]  count_q, count_d;
  logic [CoordBits-1:0]  right_q, right_d;
  logic                  accept, match, end_of_row, end_of_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      target_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i[DimRegBits-1:0];
        CfgImageHeight: height_q <= cfg_data_i[DimRegBits-1:0];
        CfgTargetColor: target_q <= cfg_data_i[ColorBits-1:0];
        default: ;
      endcase
    end
  end

  // A frame end pushes a record, so hold off intake while the queue is full
  assign pixel_ready_o = frame_ready_i;
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign match         = (pixel_color_i == target_q);
  assign end_of_row    = (col_q >= last_index(width_q));
  assign end_of_frame  = end_of_row && (row_q >= last_index(height_q));

  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    count_d = count_q;
    right_d = right_q;
    if (match) begin
      sum_x_d = sum_x_q + SumBits'(col_q);
      sum_y_d = sum_y_q + SumBits'(row_q);
      count_d = count_q + CountBits'(1);
      if (count_q == '0 || col_q > right_q) begin
        right_d = col_q;
      end
    end
    col_d = col_q + CoordBits'(1);
    row_d = row_q;
    if (end_of_row) begin
      col_d = '0;
      row_d = row_q + CoordBits'(1);
    end
  end

  assign frame_valid_o   = accept && end_of_frame;
  assign frame_o.sum_x     = sum_x_d;
  assign frame_o.sum_y     = sum_y_d;
  assign frame_o.count     = count_d;
  assign frame_o.rightmost = right_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      count_q <= '0;
      right_q <= '0;
    end else if (accept) begin
      if (end_of_frame) begin
        col_q   <= '0;
        row_q   <= '0;
        sum_x_q <= '0;
        sum_y_q <= '0;
        count_q <= '0;
        right_q <= '0;
      end else begin
        col_q   <= col_d;
        row_q   <= row_d;
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
        count_q <= count_d;
        right_q <= right_d;
      end
    end
  end

endmodule

### src/cbc_queue.sv
// Short frame-record queue between intake and the divider.
`timescale 1ns / 1ps
module cbc_queue import cbc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   not_full_o,
  input  frame_t data_i,
  input  logic   pop_i,
  output logic   not_empty_o,
  output frame_t data_o
);

  frame_t                        entry_q [QueueDepth];
  logic [QueuePtrBits-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QueuePtrBits:0]         fill_q;
  logic                          do_push, do_pop;

  assign not_full_o  = (fill_q != (QueuePtrBits+1)'(QueueDepth));
  assign not_empty_o = (fill_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign data_o      = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + QueuePtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + QueuePtrBits'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + (QueuePtrBits+1)'(1);
        2'b01:   fill_q <= fill_q - (QueuePtrBits+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

### src/cbc_back.sv
// Centroid divider and result register: one quotient bit per cycle for x and y.
`timescale 1ns / 1ps
module cbc_back import cbc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         frame_avail_i,
  output logic                         frame_pop_o,
  input  frame_t                       frame_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic                         found_o,
  output logic signed [CenterBits-1:0] center_x_o,
  output logic signed [CenterBits-1:0] center_y_o,
  output logic [CoordBits-1:0]         radius_o,
  output logic [CountBits-1:0]         match_total_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StDiv  = 1'b1;

  logic                  state_q, state_d;
  logic [StepBits-1:0]   step_q;
  logic [CountBits-1:0]  div_q;
  logic [CoordBits-1:0]  right_q;
  logic [CountBits-1:0]  rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [CoordBits-1:0]  quo_x_q, quo_y_q, quo_x_d, quo_y_d;
  logic [CountBits:0]    trial_x, trial_y;
  logic                  out_free, start, start_empty, finish;

  logic                         res_valid_q;
  logic                         found_q;
  logic signed [CenterBits-1:0] cx_q, cy_q;
  logic [CoordBits-1:0]         radius_q;
  logic [CountBits-1:0]         total_q;

  assign out_free    = !res_valid_q || res_ready_i;
  // An empty frame needs no division: take it only when the result slot is free
  assign start_empty = (state_q == StIdle) && frame_avail_i && (frame_i.count == '0) && out_free;
  assign start       = (state_q == StIdle) && frame_avail_i && (frame_i.count != '0);
  assign frame_pop_o = start || start_empty;
  assign finish      = (state_q == StDiv) && (int'(step_q) == CoordBits) && out_free;

  // Restoring step: shift the next dividend bit in, subtract when it fits
  assign trial_x = {rem_x_q, quo_x_q[CoordBits-1]};
  assign trial_y = {rem_y_q, quo_y_q[CoordBits-1]};

  always_comb begin
    if (trial_x >= {1'b0, div_q}) begin
      rem_x_d = CountBits'(trial_x - {1'b0, div_q});
      quo_x_d = {quo_x_q[CoordBits-2:0], 1'b1};
    end else begin
      rem_x_d = trial_x[CountBits-1:0];
      quo_x_d = {quo_x_q[CoordBits-2:0], 1'b0};
    end
    if (trial_y >= {1'b0, div_q}) begin
      rem_y_d = CountBits'(trial_y - {1'b0, div_q});
      quo_y_d = {quo_y_q[CoordBits-2:0], 1'b1};
    end else begin
      rem_y_d = trial_y[CountBits-1:0];
      quo_y_d = {quo_y_q[CoordBits-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start) state_d = StDiv;
      StDiv:   if (finish) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        step_q <= '0;
      end else if (state_q == StDiv && int'(step_q) != CoordBits) begin
        step_q <= step_q + StepBits'(1);
      end
    end
  end

  // The mean never exceeds the largest coordinate, so the upper dividend bits
  // already form the partial remainder and only the low bits need steps
  always_ff @(posedge clk_i) begin
    if (start) begin
      div_q   <= frame_i.count;
      right_q <= frame_i.rightmost;
      rem_x_q <= CountBits'(frame_i.sum_x[SumBits-1:CoordBits]);
      rem_y_q <= CountBits'(frame_i.sum_y[SumBits-1:CoordBits]);
      quo_x_q <= frame_i.sum_x[CoordBits-1:0];
      quo_y_q <= frame_i.sum_y[CoordBits-1:0];
    end else if (state_q == StDiv && int'(step_q) != CoordBits) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (finish || start_empty) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      found_q  <= 1'b1;
      cx_q     <= {1'b0, quo_x_q};
      cy_q     <= {1'b0, quo_y_q};
      radius_q <= right_q - quo_x_q;
      total_q  <= div_q;
    end else if (start_empty) begin
      found_q  <= 1'b0;
      cx_q     <= '1;
      cy_q     <= '1;
      radius_q <= '0;
      total_q  <= '0;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign found_o       = found_q;
  assign center_x_o    = cx_q;
  assign center_y_o    = cy_q;
  assign radius_o      = radius_q;
  assign match_total_o = total_q;

endmodule

### src/color_blob_centroid_core.sv
// A frame with no match skips the divider and gets its result registered directly;
// any other frame waits for the bit-serial divider to finish.
// Throughput: one pixel per cycle; frames shorter than the divider time stall
// intake once the two-entry frame queue fills.
// Reset: asynchronous active low; counters and sums clear, width 640, height 480, color 0.
`timescale 1ns / 1ps
module color_blob_centroid_core import cbc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [CfgDataBits-1:0]       cfg_data_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic [ColorBits-1:0]         pixel_color_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic                         found_o,
  output logic signed [CenterBits-1:0] center_x_o,
  output logic signed [CenterBits-1:0] center_y_o,
  output logic [CoordBits-1:0]         radius_o,
  output logic [CountBits-1:0]         match_total_o
);

  frame_t push_data, pop_data;
  logic   push, not_full, pop, not_empty;

  cbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_color_i (pixel_color_i),
    .frame_valid_o (push),
    .frame_ready_i (not_full),
    .frame_o       (push_data)
  );

  cbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .not_full_o  (not_full),
    .data_i      (push_data),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .data_o      (pop_data)
  );

  cbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_avail_i (not_empty),
    .frame_pop_o   (pop),
    .frame_i       (pop_data),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .found_o       (found_o),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .radius_o      (radius_o),
    .match_total_o (match_total_o)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for color_blob_centroid_core: pixel frames against a centroid predictor.
`timescale 1ns / 1ps
module tb;
  import cbc_pkg::*;

  localparam int TotalPixels = 1700;
  localparam int CalmPixels  = 300;
  localparam int QuietLimit  = 2000;
  localparam int SettleWait  = CoordBits + 8;
  localparam logic [CfgIdxBits-1:0] CfgUnused = CfgIdxBits'(3);

  typedef struct {
    logic                         found;
    logic signed [CenterBits-1:0] center_x;
    logic signed [CenterBits-1:0] center_y;
    logic [CoordBits-1:0]         radius;
    logic [CountBits-1:0]         match_total;
  } blob_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CfgIdxBits-1:0]        cfg_idx_i;
  logic [CfgDataBits-1:0]       cfg_data_i;
  logic                         pixel_valid_i;
  logic                         pixel_ready_o;
  logic [ColorBits-1:0]         pixel_color_i;
  logic                         res_valid_o;
  logic                         res_ready_i = 1'b0;
  logic                         found_o;
  logic signed [CenterBits-1:0] center_x_o;
  logic signed [CenterBits-1:0] center_y_o;
  logic [CoordBits-1:0]         radius_o;
  logic [CountBits-1:0]         match_total_o;

  color_blob_centroid_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_color_i (pixel_color_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .found_o       (found_o),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .radius_o      (radius_o),
    .match_total_o (match_total_o)
  );

  // Predictor state: geometry, color and the running frame totals
  logic [DimRegBits-1:0] m_width;
  logic [DimRegBits-1:0] m_height;
  logic [ColorBits-1:0]  m_target;
  logic [CoordBits-1:0]  col_pos;
  logic [CoordBits-1:0]  row_pos;
  logic [SumBits-1:0]    sum_col;
  logic [SumBits-1:0]    sum_row;
  logic [CountBits-1:0]  hits;
  int                    max_col;

  blob_t pending_blobs[$];
  blob_t want_blob;
  int    fail_count = 0;
  int    pixels_sent = 0;
  int    quiet_cycles = 0;
  int    ready_hold = 0;
  bit    gaps_on = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CoordBits-1:0] final_coord(input logic [DimRegBits-1:0] dim);
    if (dim == '0) return '0;
    if (int'(dim) > MaxDim) return CoordBits'(MaxDim - 1);
    return CoordBits'(int'(dim) - 1);
  endfunction

  function automatic void clear_frame();
    col_pos = '0;
    row_pos = '0;
    sum_col = '0;
    sum_row = '0;
    hits    = '0;
    max_col = -1;
  endfunction

  // Advance the frame by one pixel; queue the blob summary when the frame closes
  function automatic void track_pixel(input logic [ColorBits-1:0] color);
    logic [CoordBits-1:0] last_col;
    logic [CoordBits-1:0] last_row;
    logic                 row_done;
    logic [SumBits-1:0]   mean_x;
    logic [SumBits-1:0]   mean_y;
    blob_t                blob;
    last_col = final_coord(m_width);
    last_row = final_coord(m_height);
    row_done = col_pos >= last_col;
    if (color == m_target) begin
      sum_col += SumBits'(col_pos);
      sum_row += SumBits'(row_pos);
      hits    += 1'b1;
      if (int'(col_pos) > max_col) max_col = int'(col_pos);
    end
    if (!(row_done && row_pos >= last_row)) begin
      if (row_done) begin
        col_pos = '0;
        row_pos += 1'b1;
      end else begin
        col_pos += 1'b1;
      end
      return;
    end
    if (hits == '0) begin
      blob.found       = 1'b0;
      blob.center_x    = '1;
      blob.center_y    = '1;
      blob.radius      = '0;
      blob.match_total = '0;
    end else begin
      mean_x           = sum_col / SumBits'(hits);
      mean_y           = sum_row / SumBits'(hits);
      blob.found       = 1'b1;
      blob.center_x    = CenterBits'(mean_x);
      blob.center_y    = CenterBits'(mean_y);
      blob.radius      = CoordBits'(max_col - int'(mean_x));
      blob.match_total = hits;
    end
    pending_blobs.push_back(blob);
    clear_frame();
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [ColorBits-1:0] pick_color(input int match_pct);
    logic [ColorBits-1:0] c;
    c = ColorBits'($urandom());
    if ($urandom_range(0, 99) < match_pct) begin
      c = m_target;
    end else if ($urandom_range(0, 7) == 0) begin
      // near miss: one bit off the target
      c = m_target ^ (ColorBits'(1) << $urandom_range(0, ColorBits - 1));
    end
    return c;
  endfunction

  // Result check
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (pending_blobs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0d x=%0d y=%0d r=%0d n=%0d",
                 $time, found_o, center_x_o, center_y_o, radius_o, match_total_o);
        fail_count++;
      end else begin
        want_blob = pending_blobs.pop_front();
        compare_field("found", want_blob.found, found_o);
        compare_field("center_x", want_blob.center_x, center_x_o);
        compare_field("center_y", want_blob.center_y, center_y_o);
        compare_field("radius", want_blob.radius, radius_o);
        compare_field("match_total", want_blob.match_total, match_total_o);
      end
    end
  end

  // Result-side backpressure in random bursts
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      res_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 13);
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pixel_valid_i && pixel_ready_o) || (res_valid_o && res_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [ColorBits-1:0] color);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      pixel_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    pixel_color_i <= color;
    pixel_valid_i <= 1'b1;
    do @(posedge clk_i); while (!pixel_ready_o);
    track_pixel(color);
    pixels_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the divider go quiet
  task automatic drain_results();
    @(negedge clk_i);
    pixel_valid_i <= 1'b0;
    while (pending_blobs.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgImageWidth:  m_width  = data[DimRegBits-1:0];
      CfgImageHeight: m_height = data[DimRegBits-1:0];
      CfgTargetColor: m_target = data[ColorBits-1:0];
      default: ;
    endcase
  endtask

  // Dimension writes carry random junk above the register width
  task automatic write_dim(input logic [CfgIdxBits-1:0] idx, input int dim);
    logic [CfgDataBits-1:0] data;
    data = CfgDataBits'($urandom());
    data[DimRegBits-1:0] = DimRegBits'(dim);
    write_reg(idx, data);
  endtask

  task automatic test_reset_geometry();
    // default 640x480 frame with target 0, cut short by shrinking the geometry
    send_pixel(24'h000000);
    send_pixel(24'h123456);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    drain_results();
    write_dim(CfgImageWidth, 2);
    send_pixel(24'hFFFFFF);
    drain_results();
    write_dim(CfgImageHeight, 1);
    send_pixel(24'h000000);
    send_pixel(24'hABCDEF);
  endtask

  task automatic test_dimension_limits();
    drain_results();
    // zero width and height: every pixel is a frame
    write_dim(CfgImageWidth, 0);
    write_dim(CfgImageHeight, 0);
    write_reg(CfgTargetColor, {ColorBits{1'b1}});
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFE);
    drain_results();
    // full and oversized width, then shrink below the column counter
    write_dim(CfgImageWidth, MaxDim);
    write_dim(CfgImageHeight, 1);
    write_reg(CfgTargetColor, '0);
    send_pixel(24'h000000);
    drain_results();
    write_dim(CfgImageWidth, (1 << DimRegBits) - 1);
    send_pixel(24'h000000);
    send_pixel(24'h7FFFFF);
    send_pixel(24'h000000);
    drain_results();
    write_dim(CfgImageWidth, 3);
    send_pixel(24'h000000);
    drain_results();
    // full and oversized height, then shrink below the row counter
    write_dim(CfgImageWidth, 1);
    write_dim(CfgImageHeight, MaxDim);
    send_pixel(24'h000000);
    send_pixel(24'h800000);
    drain_results();
    write_dim(CfgImageHeight, (1 << DimRegBits) - 1);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    drain_results();
    write_dim(CfgImageHeight, 2);
    send_pixel(24'h000001);
  endtask

  task automatic test_unused_index();
    drain_results();
    write_dim(CfgImageWidth, 2);
    write_dim(CfgImageHeight, 1);
    write_reg(CfgTargetColor, 24'h5A5A5A);
    write_reg(CfgUnused, 24'hA5A5A5);
    send_pixel(24'h5A5A5A);
    send_pixel(24'hA5A5A5);
  endtask

  task automatic test_random_frames();
    int w;
    int h;
    int frame_px;
    int n;
    int match_pct;
    while (pixels_sent < TotalPixels) begin
      drain_results();
      gaps_on = (pixels_sent < TotalPixels - CalmPixels) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 15))
        0:       w = 0;
        1:       w = $urandom_range(100, 200);
        2, 3:    w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0:       h = 0;
        1:       h = $urandom_range(7, 20);
        default: h = $urandom_range(1, 6);
      endcase
      if (w > 40) h = $urandom_range(1, 2);
      write_dim(CfgImageWidth, w);
      write_dim(CfgImageHeight, h);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CfgTargetColor, '0);
          1:       write_reg(CfgTargetColor, {ColorBits{1'b1}});
          default: write_reg(CfgTargetColor, CfgDataBits'($urandom()));
        endcase
      end
      frame_px = (int'(final_coord(DimRegBits'(w))) + 1) *
                 (int'(final_coord(DimRegBits'(h))) + 1);
      n = $urandom_range(1, 4) * frame_px;
      // leave a frame unfinished now and then; the next geometry cuts into it
      if ($urandom_range(0, 5) == 0) n += $urandom_range(1, frame_px);
      if (n > TotalPixels - pixels_sent) n = TotalPixels - pixels_sent;
      match_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 100);
      repeat (n) begin
        if (pixels_sent >= TotalPixels - CalmPixels) gaps_on = 1'b0;
        send_pixel(pick_color(match_pct));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    pixel_valid_i = 1'b0;
    pixel_color_i = '0;
    m_width       = WidthReset;
    m_height      = HeightReset;
    m_target      = '0;
    clear_frame();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_geometry();
    test_dimension_limits();
    test_unused_index();
    test_random_frames();

    gaps_on = 1'b0;
    drain_results();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
